@@ design/lcm_pkg.sv @@
// shared types, constants and color tables of the level-to-color mapper
package lcm_pkg;

	localparam int RAINBOW_STEPS = 7;
	localparam int DIV_CYCLES = 8;
	localparam int DIV_CNT_W = $clog2(DIV_CYCLES);
	localparam logic [15:0] DIV_DIVIDEND = 16'd32640;
	localparam logic [7:0] FULL_SCALE_RST = 8'd235;
	localparam logic [7:0] HYSTERESIS_RST = 8'd10;

	typedef enum logic [1:0] {
		CFG_FULL_SCALE = 2'd0,
		CFG_HYSTERESIS = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] duty_level;
		logic [7:0] compare_level;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       gradient_mode;
	} out_item_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic capture;
		logic decide;
		logic div_step;
		logic mul;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic above_next;
		logic out_free;
	} dp_status_t;

	function automatic rgb_t rainbow_color(input logic [2:0] idx);
		rgb_t c;
		case (idx)
			3'd0: c = '{r: 8'd255, g: 8'd0,   b: 8'd2};
			3'd1: c = '{r: 8'd255, g: 8'd165, b: 8'd2};
			3'd2: c = '{r: 8'd255, g: 8'd255, b: 8'd2};
			3'd3: c = '{r: 8'd0,   g: 8'd241, b: 8'd20};
			3'd4: c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
			3'd5: c = '{r: 8'd75,  g: 8'd0,   b: 8'd130};
			3'd6: c = '{r: 8'd168, g: 8'd0,   b: 8'd255};
			default: c = '{r: 8'd0, g: 8'd0, b: 8'd0};
		endcase
		return c;
	endfunction

	function automatic logic [2:0] rainbow_next(input logic [2:0] idx);
		logic [3:0] inc;
		inc = {1'b0, idx} + 4'd1;
		return (inc >= 4'(RAINBOW_STEPS)) ? 3'd0 : inc[2:0];
	endfunction

endpackage

@@ design/level_to_color_mapper_top.sv @@
// top level of the level-to-color mapper
//
// use: each input transaction carries a duty level and a compare level; each one
// yields exactly one output transaction with an rgb color and a gradient_mode flag
// - hysteresis comparator lowers the compare level by the hysteresis register
//   while the previous decision was above
// - above: green to orange to red interpolation in 1/128 fixed point
// - not above: next entry of the rainbow table, index wraps after the last step
// config: cfg_index 0 = full_scale, 1 = hysteresis; other indexes are ignored;
//   cfg_ready is always high, write only while no transaction is in flight
// sequence: a rainbow result goes to the output register after the decide step,
//   a gradient result after decide, the divider steps at two quotient bits
//   each, the multiply step and the output load
// input: a new input transaction is taken only after the last one is emitted;
//   gradient mode takes longer than rainbow mode because of the radix-4 divider
//   for 32640 / (full_scale/2)
// stall: the output register holds its result until out_ready; the block keeps
//   working on the next item and waits in its last step for the register
// reset: arst_n clears the state machine, output valid, above flag and rainbow
//   index, and loads full_scale 235 and hysteresis 10
module level_to_color_mapper_top import lcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// configuration writes are always accepted
	assign cfg_ready = 1'b1;

	lcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lcm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

@@ design/lcm_ctrl.sv @@
// controller state machine of the level-to-color mapper
module lcm_ctrl import lcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECIDE = 5'b00010,
		S_DIV    = 5'b00100,
		S_MUL    = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				cnt_d      = '0;
				state_d    = status.above_next ? S_DIV : S_EMIT;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

@@ design/lcm_datapath.sv @@
// datapath of the level-to-color mapper: comparator, divider, multiplier, output register
module lcm_datapath import lcm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  in_item_t   in_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output out_item_t  out_data,
	output logic       out_valid,
	input  logic       out_ready
);

	logic [7:0]  full_scale_q, hysteresis_q;
	logic        above_q;
	logic [2:0]  rainbow_idx_q;
	logic        out_valid_q;
	out_item_t   out_q;

	in_item_t    item_s1;
	logic [6:0]  width_q;
	logic [7:0]  dot_q;
	logic        seg2_q;
	logic [15:0] quo_q;
	logic [6:0]  rem_q;
	logic [22:0] prod_q;

	// decision and segment setup
	logic [7:0] hyst_eff, lvl_clamp, dot_d;
	logic [8:0] lvl_sum;
	logic [6:0] half, width_d;
	logic       above_next, seg2_d;

	always_comb begin
		hyst_eff   = above_q ? hysteresis_q : 8'd0;
		lvl_sum    = {1'b0, item_s1.duty_level} + {1'b0, hyst_eff};
		above_next = lvl_sum > {1'b0, item_s1.compare_level};
		lvl_clamp  = (item_s1.duty_level > full_scale_q) ? full_scale_q : item_s1.duty_level;
		half       = full_scale_q[7:1];
		width_d    = (half == 7'd0) ? 7'd1 : half;
		seg2_d     = lvl_clamp > {1'b0, half};
		dot_d      = seg2_d ? (lvl_clamp - {1'b0, half}) : lvl_clamp;
	end

	// two restoring division steps per cycle
	logic [7:0]  r0, r1, wd;
	logic [6:0]  r0n, r1n;
	logic        ge0, ge1;

	always_comb begin
		wd  = {1'b0, width_q};
		r0  = {rem_q, quo_q[15]};
		ge0 = r0 >= wd;
		r0n = ge0 ? 7'(r0 - wd) : r0[6:0];
		r1  = {r0n, quo_q[14]};
		ge1 = r1 >= wd;
		r1n = ge1 ? 7'(r1 - wd) : r1[6:0];
	end

	// gradient channel from product, floor by 128 with saturation
	logic [15:0] pos_v;
	logic [23:0] neg_sum;
	logic [16:0] neg_c;
	logic [7:0]  ch_rise, ch_fall;
	rgb_t        rom_c;
	out_item_t   res;

	always_comb begin
		pos_v   = prod_q[22:7];
		ch_rise = (pos_v[15:8] != 8'd0) ? 8'd255 : pos_v[7:0];
		neg_sum = {1'b0, prod_q} + 24'd127;
		neg_c   = neg_sum[23:7];
		ch_fall = (neg_c > 17'd255) ? 8'd0 : (8'd255 - neg_c[7:0]);
		rom_c   = rainbow_color(rainbow_idx_q);
		res.gradient_mode = above_q;
		if (above_q) begin
			res.blue = 8'd0;
			if (seg2_q) begin
				res.red   = 8'd255;
				res.green = ch_fall;
			end else begin
				res.red   = ch_rise;
				res.green = 8'd255;
			end
		end else begin
			res.red   = rom_c.r;
			res.green = rom_c.g;
			res.blue  = rom_c.b;
		end
	end

	// control and configuration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q  <= FULL_SCALE_RST;
			hysteresis_q  <= HYSTERESIS_RST;
			above_q       <= 1'b0;
			rainbow_idx_q <= 3'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_FULL_SCALE: full_scale_q <= cfg_data;
					CFG_HYSTERESIS: hysteresis_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.decide) begin
				above_q <= above_next;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (!above_q) begin
					rainbow_idx_q <= rainbow_next(rainbow_idx_q);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_s1 <= in_data;
		end
		if (cmd.decide) begin
			width_q <= width_d;
			dot_q   <= dot_d;
			seg2_q  <= seg2_d;
			quo_q   <= DIV_DIVIDEND;
			rem_q   <= 7'd0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[13:0], ge0, ge1};
			rem_q <= r1n;
		end
		if (cmd.mul) begin
			prod_q <= {8'd0, quo_q[14:0]} * {15'd0, dot_q};
		end
		if (cmd.emit) begin
			out_q <= res;
		end
	end

	assign status    = '{above_next: above_next, out_free: !out_valid_q || out_ready};
	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

@@ design/lcm_checker.sv @@
// port-level assertions of the level-to-color mapper and their bind
module lcm_checker import lcm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input out_item_t  out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// gradient colors lie on green-orange-red
	a_gradient_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.gradient_mode |->
			out_data.blue == 8'd0 && (out_data.red == 8'd255 || out_data.green == 8'd255))
		else $error("gradient color off the green-orange-red path");

	// every rainbow entry has some blue
	a_rainbow_blue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.gradient_mode |-> out_data.blue != 8'd0)
		else $error("rainbow entry with no blue");

endmodule

bind level_to_color_mapper_top lcm_checker u_lcm_checker (.*);
